### src/pbt_pkg.sv
// pbt_pkg: types and constants for the periodic burst tagger
// sample and result item structs, lane flag struct, register indexes
// no dependencies
package pbt_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 64;

    localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BURST_LEN = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_STAMP_INTERVAL = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_RATE = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_SEC = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_SUBSEC = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_OFFSETS = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_COUNT = 3'd7;

    localparam logic [31:0] PERIOD_RST = 32'd1000;
    localparam logic [15:0] BURST_LEN_RST = 16'd1;
    localparam logic [15:0] STAMP_INTERVAL_RST = 16'd0;
    localparam logic [31:0] RATE_RST = 32'd1000000;
    localparam logic [31:0] START_SEC_RST = 32'd0;
    localparam logic [31:0] START_SUBSEC_RST = 32'd0;
    localparam logic [63:0] OFFSETS_RST = 64'd0;
    localparam logic [2:0] OFFSET_COUNT_RST = 3'd1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] in_i;
        logic signed [SAMPLE_BITS-1:0] in_q;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_i;
        logic signed [SAMPLE_BITS-1:0] out_q;
        logic sob;
        logic eob;
        logic stamp_valid;
        logic [31:0] stamp_seconds;
        logic [31:0] stamp_subsec;
    } t_out_item;

    typedef struct packed {
        logic sob;
        logic eob;
    } t_lane_flags;

endpackage

### src/pbt_lane.sv
// pbt_lane: start and end countdowns for one burst offset
// depends on pbt_pkg for the lane flag struct
module pbt_lane (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_reload,
    input  logic               i_step,
    input  logic [31:0]        i_offset,
    input  logic [31:0]        i_per_m1,
    input  logic               i_len_one,
    input  logic [15:0]        i_len_m2,
    output pbt_pkg::t_lane_flags o_flags
);
    import pbt_pkg::*;

    logic [31:0] r_start;
    logic [31:0] n_start;
    logic [15:0] r_end;
    logic [15:0] n_end;
    logic        r_armed;
    logic        n_armed;
    logic        w_sob;
    logic        w_eob;

    always_comb begin
        n_start = r_start;
        n_end   = r_end;
        n_armed = r_armed;
        w_sob   = 1'b0;
        w_eob   = 1'b0;
        if (r_armed) begin
            if (r_end == 16'd0) begin
                w_eob   = 1'b1;
                n_armed = 1'b0;
            end else begin
                n_end = r_end - 16'd1;
            end
        end
        if (r_start == 32'd0) begin
            w_sob   = 1'b1;
            n_start = i_per_m1;
            if (i_len_one) begin
                w_eob = 1'b1;
            end else begin
                n_armed = 1'b1;
                n_end   = i_len_m2;
            end
        end else begin
            n_start = r_start - 32'd1;
        end
    end

    assign o_flags.sob = w_sob;
    assign o_flags.eob = w_eob;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= OFFSETS_RST[31:0] & 32'd0;
            r_end   <= '0;
            r_armed <= 1'b0;
        end else if (i_reload) begin
            r_start <= i_offset;
            r_end   <= '0;
            r_armed <= 1'b0;
        end else if (i_step) begin
            r_start <= n_start;
            r_end   <= n_end;
            r_armed <= n_armed;
        end
    end

endmodule

### src/periodic_burst_tagger_unit.sv
// periodic_burst_tagger_unit: top level of the periodic burst tagger
// passes samples through with burst start/end flags and time stamps
// depends on pbt_pkg and pbt_lane
//
// usage: samples enter on the in channel (valid/ready) and leave one for one
// on the out channel with sob, eob and an optional time stamp attached.
// each offset lane counts down to its next burst start; ends follow
// burst_length - 1 samples after a start. the stamp is seconds plus a
// sample count into the second, advanced once per sample.
// an accepted sample and its flags are registered in the result register.
// one sample per cycle while the receiver keeps up; the input is taken whenever the result
// register is empty or being drained in the same cycle.
// a receiver stall holds the result and stops intake once it is full.
// configuration writes are taken every cycle on the cfg channel; writes to
// period, offsets or offset count restart the lanes, and writes to the
// start time reload the time counter.
// reset loads register defaults, restarts all lanes and the time counter,
// and empties the result register.
module periodic_burst_tagger_unit #(
    parameter int NUM_OFFSETS = 4,
    parameter int OFFSET_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  pbt_pkg::t_in_item                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output pbt_pkg::t_out_item                  o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pbt_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [pbt_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import pbt_pkg::*;

    logic [31:0] r_period;
    logic [15:0] r_burst_len;
    logic [15:0] r_interval;
    logic [31:0] r_rate;
    logic [31:0] r_start_sec;
    logic [31:0] r_start_subsec;
    logic [63:0] r_offsets;
    logic [2:0]  r_offset_count;
    logic [63:0] n_offsets;
    logic [31:0] n_start_sec;
    logic [31:0] n_start_subsec;

    logic [15:0] r_modcount;
    logic        r_first;
    logic [31:0] r_sec;
    logic [31:0] r_subsec;

    t_out_item   r_out;
    logic        r_out_valid;

    logic        w_cfg_wr;
    logic        w_lane_reload;
    logic        w_time_reload;
    logic        w_accept;
    logic [31:0] w_per;
    logic [15:0] w_len;
    logic [15:0] w_len_sat;
    logic        w_sob;
    logic        w_eob;
    logic        w_stamp;
    logic [15:0] n_modcount;
    logic [16:0] w_next_mod;
    logic [32:0] w_subsec_inc;

    t_lane_flags w_flags [NUM_OFFSETS];
    logic [NUM_OFFSETS-1:0] w_active;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;

    assign w_lane_reload = w_cfg_wr && ((i_cfg_index == REG_PERIOD)
                                     || (i_cfg_index == REG_OFFSETS)
                                     || (i_cfg_index == REG_OFFSET_COUNT));
    assign w_time_reload = w_cfg_wr && ((i_cfg_index == REG_START_SEC)
                                     || (i_cfg_index == REG_START_SUBSEC));

    assign n_offsets      = (w_cfg_wr && i_cfg_index == REG_OFFSETS) ? i_cfg_data : r_offsets;
    assign n_start_sec    = (w_cfg_wr && i_cfg_index == REG_START_SEC)
                            ? i_cfg_data[31:0] : r_start_sec;
    assign n_start_subsec = (w_cfg_wr && i_cfg_index == REG_START_SUBSEC)
                            ? i_cfg_data[31:0] : r_start_subsec;

    // zero period and zero length count as one, length saturates to period
    assign w_per = (r_period == 32'd0) ? 32'd1 : r_period;
    assign w_len = (r_burst_len == 16'd0) ? 16'd1 : r_burst_len;
    assign w_len_sat = ({16'd0, w_len} > w_per) ? w_per[15:0] : w_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period       <= PERIOD_RST;
            r_burst_len    <= BURST_LEN_RST;
            r_interval     <= STAMP_INTERVAL_RST;
            r_rate         <= RATE_RST;
            r_start_sec    <= START_SEC_RST;
            r_start_subsec <= START_SUBSEC_RST;
            r_offsets      <= OFFSETS_RST;
            r_offset_count <= OFFSET_COUNT_RST;
        end else if (w_cfg_wr) begin
            unique case (i_cfg_index)
                REG_PERIOD:         r_period       <= i_cfg_data[31:0];
                REG_BURST_LEN:      r_burst_len    <= i_cfg_data[15:0];
                REG_STAMP_INTERVAL: r_interval     <= i_cfg_data[15:0];
                REG_RATE:           r_rate         <= i_cfg_data[31:0];
                REG_START_SEC:      r_start_sec    <= i_cfg_data[31:0];
                REG_START_SUBSEC:   r_start_subsec <= i_cfg_data[31:0];
                REG_OFFSETS:        r_offsets      <= i_cfg_data;
                REG_OFFSET_COUNT:   r_offset_count <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    for (genvar g = 0; g < NUM_OFFSETS; g++) begin : g_lane
        localparam int LO = g * OFFSET_BITS;
        localparam logic [3:0] LANE_IDX = 4'(g);
        logic [31:0] w_offset;
        logic [63:0] w_shifted;

        if (LO < 64) begin : g_in_reg
            assign w_shifted = n_offsets >> LO;
            assign w_offset  = 32'(w_shifted[OFFSET_BITS-1:0]);
        end else begin : g_beyond
            assign w_shifted = '0;
            assign w_offset  = 32'(w_shifted[OFFSET_BITS-1:0]);
        end

        assign w_active[g] = (g == 0) || ({1'b0, r_offset_count} > LANE_IDX);

        pbt_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_reload  (w_lane_reload),
            .i_step    (w_accept && w_active[g]),
            .i_offset  (w_offset),
            .i_per_m1  (w_per - 32'd1),
            .i_len_one (w_len_sat == 16'd1),
            .i_len_m2  (w_len_sat - 16'd2),
            .o_flags   (w_flags[g])
        );
    end

    always_comb begin
        w_sob = 1'b0;
        w_eob = 1'b0;
        for (int k = 0; k < NUM_OFFSETS; k++) begin
            w_sob = w_sob | (w_active[k] & w_flags[k].sob);
            w_eob = w_eob | (w_active[k] & w_flags[k].eob);
        end
    end

    always_comb begin
        w_next_mod = {1'b0, r_modcount} + 17'd1;
        n_modcount = r_modcount;
        w_stamp    = 1'b0;
        if (w_sob) begin
            if (r_interval != 16'd0) begin
                if (w_next_mod >= {1'b0, r_interval}) begin
                    w_stamp    = 1'b1;
                    n_modcount = '0;
                end else begin
                    n_modcount = w_next_mod[15:0];
                end
            end
            w_stamp = w_stamp || r_first;
        end
    end

    assign w_subsec_inc = {1'b0, r_subsec} + 33'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modcount <= '0;
            r_first    <= 1'b1;
            r_sec      <= START_SEC_RST;
            r_subsec   <= START_SUBSEC_RST;
        end else if (w_time_reload) begin
            r_sec    <= n_start_sec;
            r_subsec <= n_start_subsec;
        end else if (w_accept) begin
            r_modcount <= n_modcount;
            if (w_sob) begin
                r_first <= 1'b0;
            end
            if (w_subsec_inc >= {1'b0, r_rate}) begin
                r_subsec <= '0;
                r_sec    <= r_sec + 32'd1;
            end else begin
                r_subsec <= w_subsec_inc[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out.out_i         <= i_in_data.in_i;
            r_out.out_q         <= i_in_data.in_q;
            r_out.sob           <= w_sob;
            r_out.eob           <= w_eob;
            r_out.stamp_valid   <= w_stamp;
            r_out.stamp_seconds <= w_stamp ? r_sec : 32'd0;
            r_out.stamp_subsec  <= w_stamp ? r_subsec : 32'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
